@@ rtl/arest_pkg.sv @@
`timescale 1ns / 1ps

package arest_pkg;

	// field widths
	localparam int SEC_W      = 32;
	localparam int USEC_W     = 20;
	localparam int BYTES_W    = 32;
	localparam int STATUS_W   = 3;
	localparam int SPEED_W    = 31;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// internal widths
	localparam int ESEC_W      = SEC_W + 1;      // elapsed seconds, signed
	localparam int EUSEC_W     = USEC_W + 1;     // elapsed microseconds, signed
	localparam int ACK_W       = BYTES_W + 2;    // acked bytes, signed
	localparam int DVD_W       = 36;             // acked*10 when acked is positive
	localparam int DIVISOR_W   = 47;             // signed divisor in 100 us ticks
	localparam int SPROD_W     = SEC_W + 14;     // seconds times ticks per second
	localparam int RECIP_W     = 22;
	localparam int RECIP_SHIFT = 28;
	localparam int UPROD_W     = USEC_W + RECIP_W;
	localparam int TICK_W      = UPROD_W - RECIP_SHIFT;
	localparam int DIV_STAGES  = DVD_W;

	// constants
	localparam logic signed [EUSEC_W-1:0] USEC_PER_SEC  = 21'sd1000000;
	localparam logic [13:0]               TICKS_PER_SEC = 14'd10000;
	// ceil(2^28 / 100): exact floor division by 100 for any 20-bit value
	localparam logic [RECIP_W-1:0]        RECIP_100     = 22'd2684355;
	localparam logic signed [ACK_W-1:0]   ACK_SMALL     = 34'sd1000;
	localparam logic [SPEED_W-1:0]        SPEED_MAX     = 31'h7FFF_FFFF;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_OVERFLOW  = 3'd1,
		ST_SLOW      = 3'd2,
		ST_VERY_SLOW = 3'd3,
		ST_TOO_FAST  = 3'd4,
		ST_ZERO_DIV  = 3'd5
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_WINDOW = 2'd0,
		CFG_LONG_SEC   = 2'd1,
		CFG_LONG_USEC  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [SEC_W-1:0]          start_sec;
		logic [USEC_W-1:0]         start_usec;
		logic [SEC_W-1:0]          stop_sec;
		logic [USEC_W-1:0]         stop_usec;
		logic signed [BYTES_W-1:0] bytes_before;
		logic signed [BYTES_W-1:0] bytes_now;
		logic signed [BYTES_W-1:0] bytes_added;
	} sample_t;

	typedef struct packed {
		logic [USEC_W-1:0] min_window_usec;
		logic [SEC_W-1:0]  long_wait_sec;
		logic [USEC_W-1:0] long_wait_usec;
	} cfg_t;

	// one slot of the division pipeline
	typedef struct packed {
		logic             valid;
		status_t          status;
		logic [DVD_W-1:0] rem;
		logic [DVD_W-1:0] dq;    // dividend bits shift out, quotient bits shift in
		logic [DVD_W-1:0] dvs;
	} div_stage_t;

endpackage

@@ rtl/arest_sample_if.sv @@
`timescale 1ns / 1ps

interface arest_sample_if;
	logic                                   valid;
	logic                                   ready;
	logic [arest_pkg::SEC_W-1:0]            start_sec;
	logic [arest_pkg::USEC_W-1:0]           start_usec;
	logic [arest_pkg::SEC_W-1:0]            stop_sec;
	logic [arest_pkg::USEC_W-1:0]           stop_usec;
	logic signed [arest_pkg::BYTES_W-1:0]   bytes_before;
	logic signed [arest_pkg::BYTES_W-1:0]   bytes_now;
	logic signed [arest_pkg::BYTES_W-1:0]   bytes_added;

	modport source (
		output valid, start_sec, start_usec, stop_sec, stop_usec,
		       bytes_before, bytes_now, bytes_added,
		input  ready
	);
	modport sink (
		input  valid, start_sec, start_usec, stop_sec, stop_usec,
		       bytes_before, bytes_now, bytes_added,
		output ready
	);
endinterface

@@ rtl/arest_result_if.sv @@
`timescale 1ns / 1ps

interface arest_result_if;
	logic                            valid;
	logic                            ready;
	logic [arest_pkg::STATUS_W-1:0]  status;
	logic [arest_pkg::SPEED_W-1:0]   speed;

	modport source (output valid, status, speed, input ready);
	modport sink (input valid, status, speed, output ready);
endinterface

@@ rtl/arest_front.sv @@
`timescale 1ns / 1ps

module arest_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic                   sample_valid,
	input  arest_pkg::sample_t     sample_data,
	input  arest_pkg::cfg_t        cfg,
	output arest_pkg::div_stage_t  div_head
);

	// stage 1: elapsed time with borrow, acked bytes
	logic signed [arest_pkg::EUSEC_W-1:0] usec_raw;
	logic signed [arest_pkg::EUSEC_W-1:0] e_usec;
	logic                                 borrow;
	logic signed [arest_pkg::ESEC_W-1:0]  e_sec;
	logic signed [arest_pkg::ACK_W-1:0]   acked;

	logic                                 valid_s1;
	logic signed [arest_pkg::ESEC_W-1:0]  e_sec_s1;
	logic signed [arest_pkg::EUSEC_W-1:0] e_usec_s1;
	logic signed [arest_pkg::ACK_W-1:0]   acked_s1;
	logic                                 ovf_s1;

	always_comb begin
		usec_raw = $signed({1'b0, sample_data.stop_usec})
		         - $signed({1'b0, sample_data.start_usec});
		borrow   = usec_raw[arest_pkg::EUSEC_W-1];
		e_usec   = borrow ? usec_raw + arest_pkg::USEC_PER_SEC : usec_raw;
		e_sec    = $signed({1'b0, sample_data.stop_sec})
		         - $signed({1'b0, sample_data.start_sec})
		         - $signed({{(arest_pkg::ESEC_W-1){1'b0}}, borrow});
		acked    = $signed({{2{sample_data.bytes_before[arest_pkg::BYTES_W-1]}},
		                    sample_data.bytes_before})
		         + $signed({{2{sample_data.bytes_added[arest_pkg::BYTES_W-1]}},
		                    sample_data.bytes_added})
		         - $signed({{2{sample_data.bytes_now[arest_pkg::BYTES_W-1]}},
		                    sample_data.bytes_now});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			e_sec_s1  <= e_sec;
			e_usec_s1 <= e_usec;
			acked_s1  <= acked;
			ovf_s1    <= sample_data.bytes_added[arest_pkg::BYTES_W-1];
		end
	end

	// stage 2: classify, start the divisor and dividend products
	logic signed [arest_pkg::ESEC_W-1:0]  long_sec_x;
	logic signed [arest_pkg::EUSEC_W-1:0] long_usec_x;
	logic signed [arest_pkg::EUSEC_W-1:0] min_usec_x;
	logic                                 lt_long;
	logic                                 lt_min;
	logic signed [arest_pkg::EUSEC_W-1:0] usec_neg;
	logic [arest_pkg::USEC_W-1:0]         usec_mag;
	arest_pkg::status_t                   status_c2;

	logic                                 valid_s2;
	arest_pkg::status_t                   status_s2;
	logic                                 neg_s2;
	logic [arest_pkg::UPROD_W-1:0]        uprod_s2;
	logic [arest_pkg::SPROD_W-1:0]        sprod_s2;
	logic [arest_pkg::DVD_W-1:0]          dvd_s2;

	always_comb begin
		long_sec_x  = $signed({1'b0, cfg.long_wait_sec});
		long_usec_x = $signed({1'b0, cfg.long_wait_usec});
		min_usec_x  = $signed({1'b0, cfg.min_window_usec});
		lt_long = (e_sec_s1 != long_sec_x) ? (e_sec_s1 < long_sec_x)
		                                    : (e_usec_s1 < long_usec_x);
		lt_min  = (e_sec_s1 != '0) ? e_sec_s1[arest_pkg::ESEC_W-1]
		                           : (e_usec_s1 < min_usec_x);
		usec_neg = -e_usec_s1;
		usec_mag = e_usec_s1[arest_pkg::EUSEC_W-1] ? usec_neg[arest_pkg::USEC_W-1:0]
		                                           : e_usec_s1[arest_pkg::USEC_W-1:0];
		if (ovf_s1) begin
			status_c2 = arest_pkg::ST_OVERFLOW;
		end else if (acked_s1 <= arest_pkg::ACK_SMALL) begin
			status_c2 = lt_long ? arest_pkg::ST_SLOW : arest_pkg::ST_VERY_SLOW;
		end else if (lt_min) begin
			status_c2 = arest_pkg::ST_TOO_FAST;
		end else begin
			status_c2 = arest_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	// seconds are non-negative whenever the divide path is taken
	always_ff @(posedge clk) begin
		if (adv) begin
			status_s2 <= status_c2;
			neg_s2    <= e_usec_s1[arest_pkg::EUSEC_W-1];
			uprod_s2  <= usec_mag * arest_pkg::RECIP_100;
			sprod_s2  <= e_sec_s1[arest_pkg::SEC_W-1:0] * arest_pkg::TICKS_PER_SEC;
			dvd_s2    <= {acked_s1[arest_pkg::ACK_W-2:0], 3'b000}
			           + {2'b00, acked_s1[arest_pkg::ACK_W-2:0], 1'b0};
		end
	end

	// stage 3: divisor in 100 us ticks, zero check, divider operands
	logic [arest_pkg::TICK_W-1:0]           usec_ticks;
	logic signed [arest_pkg::DIVISOR_W-1:0] sec_x;
	logic signed [arest_pkg::DIVISOR_W-1:0] tick_x;
	logic signed [arest_pkg::DIVISOR_W-1:0] divisor;
	logic                                   div_bad;
	logic                                   div_big;
	arest_pkg::status_t                     status_c3;
	logic                                   go;

	logic                                   valid_s3;
	arest_pkg::status_t                     status_s3;
	logic [arest_pkg::DVD_W-1:0]            dq_s3;
	logic [arest_pkg::DVD_W-1:0]            dvs_s3;

	always_comb begin
		usec_ticks = uprod_s2[arest_pkg::RECIP_SHIFT +: arest_pkg::TICK_W];
		sec_x      = $signed({1'b0, sprod_s2});
		tick_x     = $signed({{(arest_pkg::DIVISOR_W-arest_pkg::TICK_W){1'b0}}, usec_ticks});
		divisor    = neg_s2 ? sec_x - tick_x : sec_x + tick_x;
		div_bad    = divisor[arest_pkg::DIVISOR_W-1] || (divisor == '0);
		div_big    = |divisor[arest_pkg::DIVISOR_W-1:arest_pkg::DVD_W];
		status_c3  = (status_s2 == arest_pkg::ST_OK && div_bad) ? arest_pkg::ST_ZERO_DIV
		                                                         : status_s2;
		// a divisor beyond the dividend range gives a zero quotient
		go         = (status_c3 == arest_pkg::ST_OK) && !div_big;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s3 <= status_c3;
			dq_s3     <= go ? dvd_s2 : '0;
			dvs_s3    <= go ? divisor[arest_pkg::DVD_W-1:0]
			                : {{(arest_pkg::DVD_W-1){1'b0}}, 1'b1};
		end
	end

	// head of the divider
	always_comb begin
		div_head.valid  = valid_s3;
		div_head.status = status_s3;
		div_head.rem    = '0;
		div_head.dq     = dq_s3;
		div_head.dvs    = dvs_s3;
	end

endmodule

@@ rtl/arest_div_stage.sv @@
`timescale 1ns / 1ps

module arest_div_stage (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  arest_pkg::div_stage_t  stage_in,
	output arest_pkg::div_stage_t  stage_out
);

	logic [arest_pkg::DVD_W:0]   trial;
	logic [arest_pkg::DVD_W:0]   diff;
	logic                        take;
	logic [arest_pkg::DVD_W-1:0] rem_next;

	logic                        valid_s1;
	arest_pkg::status_t          status_s1;
	logic [arest_pkg::DVD_W-1:0] rem_s1;
	logic [arest_pkg::DVD_W-1:0] dq_s1;
	logic [arest_pkg::DVD_W-1:0] dvs_s1;

	// one restoring step: bring down the next dividend bit, subtract if it fits
	always_comb begin
		trial    = {stage_in.rem, stage_in.dq[arest_pkg::DVD_W-1]};
		diff     = trial - {1'b0, stage_in.dvs};
		take     = !diff[arest_pkg::DVD_W];
		rem_next = take ? diff[arest_pkg::DVD_W-1:0] : trial[arest_pkg::DVD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= stage_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s1 <= stage_in.status;
			rem_s1    <= rem_next;
			dq_s1     <= {stage_in.dq[arest_pkg::DVD_W-2:0], take};
			dvs_s1    <= stage_in.dvs;
		end
	end

	always_comb begin
		stage_out.valid  = valid_s1;
		stage_out.status = status_s1;
		stage_out.rem    = rem_s1;
		stage_out.dq     = dq_s1;
		stage_out.dvs    = dvs_s1;
	end

endmodule

@@ rtl/ack_rate_estimator.sv @@
`timescale 1ns / 1ps

// Acked-byte rate estimator. Each request on the sample channel is one
// measurement window and yields exactly one result, in order: a status code
// and, when the status is ok, the speed as acked bytes times ten per 100 us
// of elapsed time, saturated to 31 bits. The block takes one request every
// clock cycle while the pipeline advances. Between acceptance and the
// result being offered lie the timestamp, byte and divisor arithmetic
// stages, a one-bit-per-stage restoring divider (one stage per dividend bit),
// and the output register. The whole pipeline moves as one; it holds only
// while a result sits in the output register and is not taken, and requests
// and empty slots behind it are kept as they are. The user must write the
// three thresholds via the cfg port with no request in flight; not enforced.
module ack_rate_estimator (
	input  logic                               clk,
	input  logic                               arst_n,
	arest_sample_if.sink                       sample,
	arest_result_if.source                     result,
	input  logic                               cfg_we,
	input  logic [arest_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [arest_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	// configuration registers
	logic [arest_pkg::USEC_W-1:0] min_window_usec_q;
	logic [arest_pkg::SEC_W-1:0]  long_wait_sec_q;
	logic [arest_pkg::USEC_W-1:0] long_wait_usec_q;
	arest_pkg::cfg_t              cfg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_window_usec_q <= '0;
			long_wait_sec_q   <= '0;
			long_wait_usec_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				arest_pkg::CFG_MIN_WINDOW: begin
					min_window_usec_q <= cfg_wdata[arest_pkg::USEC_W-1:0];
				end
				arest_pkg::CFG_LONG_SEC: begin
					long_wait_sec_q <= cfg_wdata[arest_pkg::SEC_W-1:0];
				end
				arest_pkg::CFG_LONG_USEC: begin
					long_wait_usec_q <= cfg_wdata[arest_pkg::USEC_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.min_window_usec = min_window_usec_q;
	assign cfg.long_wait_sec   = long_wait_sec_q;
	assign cfg.long_wait_usec  = long_wait_usec_q;

	// pipeline advance: output slot empty or being taken
	logic out_valid_q;
	logic adv;

	assign adv          = !out_valid_q || result.ready;
	assign sample.ready = adv;

	// gather the request
	arest_pkg::sample_t sample_data;

	assign sample_data.start_sec    = sample.start_sec;
	assign sample_data.start_usec   = sample.start_usec;
	assign sample_data.stop_sec     = sample.stop_sec;
	assign sample_data.stop_usec    = sample.stop_usec;
	assign sample_data.bytes_before = sample.bytes_before;
	assign sample_data.bytes_now    = sample.bytes_now;
	assign sample_data.bytes_added  = sample.bytes_added;

	// front stages and divider chain
	arest_pkg::div_stage_t chain [arest_pkg::DIV_STAGES+1];

	arest_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.sample_valid (sample.valid),
		.sample_data  (sample_data),
		.cfg          (cfg),
		.div_head     (chain[0])
	);

	for (genvar i = 0; i < arest_pkg::DIV_STAGES; i++) begin : g_div
		arest_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.stage_in  (chain[i]),
			.stage_out (chain[i+1])
		);
	end

	// saturate and register the result
	arest_pkg::div_stage_t          last;
	logic [arest_pkg::SPEED_W-1:0]  speed_d;
	arest_pkg::status_t             status_q;
	logic [arest_pkg::SPEED_W-1:0]  speed_q;

	assign last = chain[arest_pkg::DIV_STAGES];

	always_comb begin
		if (last.status != arest_pkg::ST_OK) begin
			speed_d = '0;
		end else if (|last.dq[arest_pkg::DVD_W-1:arest_pkg::SPEED_W]) begin
			speed_d = arest_pkg::SPEED_MAX;
		end else begin
			speed_d = last.dq[arest_pkg::SPEED_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q <= last.status;
			speed_q  <= speed_d;
		end
	end

	assign result.valid  = out_valid_q;
	assign result.status = status_q;
	assign result.speed  = speed_q;

endmodule

@@ rtl/arest_chk.sv @@
`timescale 1ns / 1ps

module arest_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              sample_ready,
	input logic                              result_valid,
	input logic                              result_ready,
	input logic [arest_pkg::STATUS_W-1:0]    result_status,
	input logic [arest_pkg::SPEED_W-1:0]     result_speed
);

	// a result offered and not taken stays offered
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

	// an empty or draining output slot always lets a request in
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!result_valid || result_ready) |-> sample_ready)
		else $error("sample stalled with free output slot");

	// status codes stay within the defined set
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result_status <= arest_pkg::ST_ZERO_DIV))
		else $error("undefined status code");

	// speed only carries a value for an ok window
	a_speed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_status != arest_pkg::ST_OK) |-> (result_speed == '0))
		else $error("nonzero speed with non-ok status");

endmodule

bind ack_rate_estimator arest_chk u_arest_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.sample_ready  (sample.ready),
	.result_valid  (result.valid),
	.result_ready  (result.ready),
	.result_status (result.status),
	.result_speed  (result.speed)
);
